/* sv/text_to_int64_parser_defines.svh */
// ---------------------------------------------------------------------------
// text_to_int64_parser assertion macros
// Shared concurrent assertion forms for the parser modules.
// ---------------------------------------------------------------------------
`ifndef TEXT_TO_INT64_PARSER_DEFINES_SVH
`define TEXT_TO_INT64_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ttip_pkg.sv */
// ---------------------------------------------------------------------------
// ttip_pkg
// Types and constants shared by the text-to-int64 parser modules.
// ---------------------------------------------------------------------------
package ttip_pkg;

  localparam int unsigned CH_W      = 16;
  localparam int unsigned IGN_SLOTS = 4;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned NUM_W     = 64;
  localparam int unsigned HCNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned OUT_W     = 88;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [NUM_W-1:0]  MIN_NEG   = 64'h8000_0000_0000_0000;
  localparam logic [NUM_W-1:0]  DEC_LIM   = MIN_NEG / 64'd10;
  localparam logic [3:0]        DEC_LAST  = 4'(MIN_NEG % 64'd10);
  localparam logic [HCNT_W-1:0] HEX_LIMIT = 5'd16;
  localparam logic [IDX_W-1:0]  IDX_MAX   = {IDX_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUFFIX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGN0   = 3'd2;

  // Characters of interest
  localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CH_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CH_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CH_W-1:0] CH_LX    = 16'h0078;
  localparam logic [CH_W-1:0] CH_UX    = 16'h0058;
  localparam logic [CH_W-1:0] CH_0     = 16'h0030;
  localparam logic [CH_W-1:0] CH_9     = 16'h0039;
  localparam logic [CH_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CH_W-1:0] CH_LF    = 16'h0066;
  localparam logic [CH_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CH_W-1:0] CH_UF    = 16'h0046;

  typedef enum logic [2:0] {
    CLS_SKIP  = 3'd0,
    CLS_PLUS  = 3'd1,
    CLS_MINUS = 3'd2,
    CLS_X     = 3'd3,
    CLS_DEC   = 3'd4,
    CLS_HEXL  = 3'd5,
    CLS_OTHER = 3'd6,
    CLS_END   = 3'd7
  } cls_e;

  typedef enum logic [1:0] {
    STY_NONE = 2'd0,
    STY_POS  = 2'd1,
    STY_NEG  = 2'd2,
    STY_HEX  = 2'd3
  } style_e;

  typedef struct packed {
    logic                            signed_mode;
    logic                            allow_suffix;
    logic [IGN_SLOTS-1:0][CH_W-1:0]  ign;
  } cfg_t;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic              ok;
    logic [NUM_W-1:0]  number;
    style_e            style;
    logic              suffix_found;
    logic [POS_W-1:0]  suffix_pos;
  } result_t;

endpackage

/* sv/ttip_front.sv */
// ---------------------------------------------------------------------------
// ttip_front
// Classifies each incoming character into a token class and digit value.
// ---------------------------------------------------------------------------
module ttip_front import ttip_pkg::*; (
  input  cfg_t            cfg_i,
  input  logic [CH_W-1:0] ch_i,
  input  logic            end_mark_i,
  output item_t           item_o
);

  logic skip;
  logic is_dec;
  logic is_lhex;
  logic is_uhex;

  always_comb begin
    skip = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
    for (int i = 0; i < IGN_SLOTS; i++) begin
      if ((cfg_i.ign[i] != '0) && (cfg_i.ign[i] == ch_i)) begin
        skip = 1'b1;
      end
    end
  end

  assign is_dec  = (ch_i >= CH_0) && (ch_i <= CH_9);
  assign is_lhex = (ch_i >= CH_LA) && (ch_i <= CH_LF);
  assign is_uhex = (ch_i >= CH_UA) && (ch_i <= CH_UF);

  always_comb begin
    item_o.digit = ch_i[3:0];
    priority if (end_mark_i) begin
      item_o.cls = CLS_END;
    end else if (skip) begin
      item_o.cls = CLS_SKIP;
    end else if (ch_i == CH_PLUS) begin
      item_o.cls = CLS_PLUS;
    end else if (ch_i == CH_MINUS) begin
      // a minus outside signed mode is just a foreign character
      item_o.cls = cfg_i.signed_mode ? CLS_MINUS : CLS_OTHER;
    end else if ((ch_i == CH_LX) || (ch_i == CH_UX)) begin
      item_o.cls = CLS_X;
    end else if (is_dec) begin
      item_o.cls = CLS_DEC;
    end else if (is_lhex || is_uhex) begin
      item_o.cls   = CLS_HEXL;
      item_o.digit = {1'b0, ch_i[2:0]} + 4'd9;
    end else begin
      item_o.cls = CLS_OTHER;
    end
  end

endmodule

/* sv/ttip_queue.sv */
// ---------------------------------------------------------------------------
// ttip_queue
// Short FIFO of classified items between the front and back parts.
// ---------------------------------------------------------------------------
`include "text_to_int64_parser_defines.svh"

module ttip_queue import ttip_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t pop_data_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TTIP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `TTIP_ASSERT_NXT(a_push_only, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "push lost")

endmodule

/* sv/ttip_back.sv */
// ---------------------------------------------------------------------------
// ttip_back
// Parse state machine: accumulates digits and builds the end-of-string result.
// ---------------------------------------------------------------------------
`include "text_to_int64_parser_defines.svh"

module ttip_back import ttip_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic [NUM_W-1:0]  accum_q, accum_d;
  logic              neg_q, neg_d;
  logic              dec_q, dec_d;
  logic              atmin_q, atmin_d;
  logic              hex_q, hex_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic              stop_q, stop_d;
  logic              fail_q, fail_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              sfx_vld_q, sfx_vld_d;
  logic [POS_W-1:0]  sfx_pos_q, sfx_pos_d;

  logic              res_valid_q;
  result_t           res_q, res_d;

  logic              is_end;
  logic              res_free;
  logic              take;
  logic              acc_zero;
  logic              foreign;
  logic [NUM_W-1:0]  acc_x10;
  logic [HCNT_W-1:0] hcnt_inc;

  assign is_end     = (item_i.cls == CLS_END);
  assign res_free   = !res_valid_q || res_ready_i;
  assign item_pop_o = item_valid_i && (!is_end || res_free);
  assign take       = item_pop_o;
  assign acc_zero   = (accum_q == '0);
  assign acc_x10    = (accum_q << 3) + (accum_q << 1) + NUM_W'(item_i.digit);
  assign hcnt_inc   = hcnt_q + 1'b1;

  // Per-character state update
  always_comb begin
    accum_d   = accum_q;
    neg_d     = neg_q;
    dec_d     = dec_q;
    atmin_d   = atmin_q;
    hex_d     = hex_q;
    hcnt_d    = hcnt_q;
    stop_d    = stop_q;
    fail_d    = fail_q;
    idx_d     = idx_q;
    sfx_vld_d = sfx_vld_q;
    sfx_pos_d = sfx_pos_q;
    foreign   = 1'b0;

    if (take && is_end) begin
      // string closed: clear the parse state
      accum_d   = '0;
      neg_d     = 1'b0;
      dec_d     = 1'b0;
      atmin_d   = 1'b0;
      hex_d     = 1'b0;
      hcnt_d    = '0;
      stop_d    = 1'b0;
      fail_d    = 1'b0;
      idx_d     = '0;
      sfx_vld_d = 1'b0;
      sfx_pos_d = '0;
    end else if (take) begin
      if (idx_q != IDX_MAX) begin
        idx_d = idx_q + 1'b1;
      end
      priority if (fail_q || stop_q || (item_i.cls == CLS_SKIP)) begin
        // drop the character
      end else if ((item_i.cls == CLS_PLUS) && acc_zero) begin
        // leading plus is a no-op
      end else if ((item_i.cls == CLS_MINUS) && !hex_q && !neg_q && acc_zero) begin
        neg_d = 1'b1;
      end else if ((item_i.cls == CLS_X) && !hex_q && !neg_q && acc_zero) begin
        hex_d = 1'b1;
      end else if (!hex_q && (item_i.cls == CLS_DEC)) begin
        dec_d = 1'b1;
        priority if (atmin_q) begin
          fail_d = 1'b1;
        end else if (cfg_i.signed_mode) begin
          priority if ((accum_q > DEC_LIM) ||
                       ((accum_q == DEC_LIM) && (item_i.digit > DEC_LAST))) begin
            fail_d = 1'b1;
          end else if ((accum_q == DEC_LIM) && (item_i.digit == DEC_LAST)) begin
            // exactly 2^63: legal only as the magnitude of a negative value
            accum_d = acc_x10;
            if (neg_q) begin
              atmin_d = 1'b1;
            end else begin
              fail_d = 1'b1;
            end
          end else begin
            accum_d = acc_x10;
          end
        end else begin
          accum_d = acc_x10;
        end
      end else if (hex_q && ((item_i.cls == CLS_DEC) || (item_i.cls == CLS_HEXL))) begin
        hcnt_d = hcnt_inc;
        if (hcnt_inc > HEX_LIMIT) begin
          fail_d = 1'b1;
        end else begin
          accum_d = {accum_q[NUM_W-5:0], item_i.digit};
        end
      end else begin
        foreign = 1'b1;
      end

      if (foreign) begin
        if (cfg_i.allow_suffix) begin
          stop_d    = 1'b1;
          sfx_vld_d = 1'b1;
          sfx_pos_d = POS_W'(idx_q);
        end else begin
          fail_d = 1'b1;
        end
      end
    end
  end

  // Result built from the state seen by the end item
  always_comb begin
    res_d.ok           = !fail_q && (hex_q ? (hcnt_q != '0) : dec_q);
    res_d.number       = '0;
    res_d.style        = STY_NONE;
    res_d.suffix_found = !fail_q && sfx_vld_q;
    res_d.suffix_pos   = (!fail_q && sfx_vld_q) ? sfx_pos_q : '0;
    if (res_d.ok) begin
      res_d.number = neg_q ? ('0 - accum_q) : accum_q;
      res_d.style  = hex_q ? STY_HEX : (neg_q ? STY_NEG : STY_POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      neg_q       <= 1'b0;
      dec_q       <= 1'b0;
      atmin_q     <= 1'b0;
      hex_q       <= 1'b0;
      hcnt_q      <= '0;
      stop_q      <= 1'b0;
      fail_q      <= 1'b0;
      idx_q       <= '0;
      sfx_vld_q   <= 1'b0;
      sfx_pos_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      accum_q   <= accum_d;
      neg_q     <= neg_d;
      dec_q     <= dec_d;
      atmin_q   <= atmin_d;
      hex_q     <= hex_d;
      hcnt_q    <= hcnt_d;
      stop_q    <= stop_d;
      fail_q    <= fail_d;
      idx_q     <= idx_d;
      sfx_vld_q <= sfx_vld_d;
      sfx_pos_q <= sfx_pos_d;
      if (take && is_end) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_end) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `TTIP_ASSERT_IMP(a_fail_stop_excl, 1'b1, !(fail_q && stop_q), "failed and stopped both set")
  `TTIP_ASSERT_NXT(a_dead_hold, take && !is_end && (fail_q || stop_q), $stable(accum_q), "accumulator moved after fail or suffix")
  `TTIP_ASSERT_IMP(a_ok_style, res_valid_q && res_q.ok, res_q.style != STY_NONE, "ok result without style")
  `TTIP_ASSERT_IMP(a_atmin_neg, atmin_q, neg_q && (accum_q == MIN_NEG), "min-negative flag without its value")

endmodule

/* sv/text_to_int64_parser.sv */
// ---------------------------------------------------------------------------
// text_to_int64_parser
// Streams 16-bit characters and parses each string into a 64-bit integer.
// ---------------------------------------------------------------------------
// One character enters per item on the slave stream; an item with tlast set
// ends the string (its tdata is ignored) and produces exactly one result on
// the master stream. Blanks, tabs and up to four programmable characters are
// skipped anywhere. Decimal (with optional leading '-' in signed mode) and
// 'x'-prefixed hex of at most 16 digits are accepted. In signed mode decimal
// overflow fails the string, with -2^63 allowed; unsigned decimal wraps.
// A foreign character either fails the string or, with allow_suffix set,
// marks the suffix start and stops the parse.
// Throughput: one item per clock cycle, sustained while no end item waits
// for a result still held on m_axis_tready. The limit is the parse state
// update in the back part, which consumes one character per cycle
// (multiply-by-ten as shift-add, overflow compare). An accepted end item
// passes through the queue and then loads the result register behind
// m_axis_tvalid. A two-entry queue separates the classifier from the
// parser, and the result register lets new characters flow while a
// result waits on m_axis_tready. Configuration is to be written by the
// user only while the block is idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module text_to_int64_parser import ttip_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // character stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CH_W-1:0]      s_axis_tdata,   // [15:0] ch
  input  logic                 s_axis_tlast,   // end of string
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] ok, [64:1] number, [66:65] style, [67] suffix_found,
  // [83:68] suffix_pos, [87:84] zero
  output logic [OUT_W-1:0]     m_axis_tdata
);

  cfg_t    cfg_q;
  item_t   front_item;
  item_t   q_item;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  result_t res;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SIGNED) begin
        cfg_q.signed_mode <= cfg_wdata_i[0];
      end else if (cfg_idx_i == REG_SUFFIX) begin
        cfg_q.allow_suffix <= cfg_wdata_i[0];
      end else begin
        for (int i = 0; i < IGN_SLOTS; i++) begin
          if (cfg_idx_i == REG_IGN0 + CFG_IDX_W'(i)) begin
            cfg_q.ign[i] <= cfg_wdata_i;
          end
        end
      end
    end
  end

  // Front: classify the character
  ttip_front u_front (
    .cfg_i      (cfg_q),
    .ch_i       (s_axis_tdata),
    .end_mark_i (s_axis_tlast),
    .item_o     (front_item)
  );

  assign s_axis_tready = !q_full;

  // Queue: decouple the classifier from the parser
  ttip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_item)
  );

  // Back: advance the parse state and hold the result
  ttip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {4'b0000, res.suffix_pos, res.suffix_found, res.style,
                         res.number, res.ok};

endmodule
